// File: sv/wfb_pkg.sv
// Shared types and codes for the window frame-buffer draw engine.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package wfb_pkg;

	localparam int BUFFER_PIXELS_DEF = 65536;

	// command codes
	localparam logic [2:0] CMD_DOT   = 3'd0;
	localparam logic [2:0] CMD_HSPAN = 3'd1;
	localparam logic [2:0] CMD_VSPAN = 3'd2;
	localparam logic [2:0] CMD_RECT  = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y    = 2'd1;
	localparam logic [1:0] CFG_WINDOW_W    = 2'd2;
	localparam logic [1:0] CFG_PIXELS_USED = 2'd3;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] window_width;
		logic [16:0] buffer_pixels_used;
	} cfg_t;

endpackage

`default_nettype wire

// File: sv/wfb_pixel_mem.sv
// Pixel store: one write port and one registered read port, 16-bit entries.
// Depends on wfb_pkg for the default depth.
`default_nettype none

module wfb_pixel_mem #(
	parameter int DEPTH = wfb_pkg::BUFFER_PIXELS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/wfb_addr_unit.sv
// Two-stage pixel address pipe: (y - origin_y) * width + (x - origin_x), mod 2^32.
// Depends on wfb_pkg for the configuration struct.
`default_nettype none

module wfb_addr_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire wfb_pkg::cfg_t cfg,
	input  wire logic         req,
	input  wire logic [15:0]  x,
	input  wire logic [15:0]  y,
	output logic              valid,
	output logic [31:0]       addr
);

	logic signed [16:0] dy;
	logic signed [16:0] dx;
	logic signed [16:0] wd;
	logic signed [33:0] prod;

	logic [31:0]        prod_s1;
	logic signed [16:0] dx_s1;
	logic               valid_s1;
	logic [31:0]        addr_s2;
	logic               valid_s2;

	assign dy   = $signed({1'b0, y}) - $signed({1'b0, cfg.origin_y});
	assign dx   = $signed({1'b0, x}) - $signed({1'b0, cfg.origin_x});
	assign wd   = $signed({1'b0, cfg.window_width});
	assign prod = dy * wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod[31:0];
		dx_s1   <= dx;
		// negative offsets wrap, as the sign extension to 32 bits gives
		addr_s2 <= prod_s1 + {{15{dx_s1[16]}}, dx_s1};
	end

	assign valid = valid_s2;
	assign addr  = addr_s2;

endmodule

`default_nettype wire

// File: sv/wfb_ctrl.sv
// Command sequencer: walks rows and pixels of a command, one pixel write per cycle
// in a row; issues reads. Depends on wfb_pkg; drives wfb_addr_unit, wfb_pixel_mem.
`default_nettype none

module wfb_ctrl #(
	parameter int BUFFER_PIXELS = wfb_pkg::BUFFER_PIXELS_DEF,
	localparam int AW = (BUFFER_PIXELS > 1) ? $clog2(BUFFER_PIXELS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire wfb_pkg::cfg_t cfg,
	input  wire logic          start,
	input  wire logic [2:0]    command,
	input  wire logic [15:0]   x_pos,
	input  wire logic [15:0]   y_pos,
	input  wire logic [15:0]   extent_x,
	input  wire logic [15:0]   extent_y,
	input  wire logic [15:0]   color,
	output logic               busy,
	output logic               addr_req,
	output logic [15:0]        addr_x,
	output logic [15:0]        addr_y,
	input  wire logic          addr_valid,
	input  wire logic [31:0]   addr_base,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [15:0]        mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  wire logic [15:0]   mem_rdata,
	output logic               done,
	output logic [15:0]        read_color,
	output logic               status
);

	localparam int PIX_W = $clog2(BUFFER_PIXELS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADDR   = 3'd1;
	localparam logic [2:0] S_ROW    = 3'd2;
	localparam logic [2:0] S_RUN    = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;

	logic [2:0]       state_q;
	logic             done_q;
	logic [2:0]       cmd_q;
	logic [15:0]      count_q;
	logic [15:0]      rows_q;
	logic [15:0]      color_q;
	logic [31:0]      row_addr_q;
	logic [PIX_W-1:0] pix_q;
	logic [15:0]      col_q;
	logic [15:0]      read_color_q;
	logic             status_q;

	logic [15:0]      x_lo, x_hi, y_lo, y_hi;
	logic [15:0]      cnt, rws;
	logic [PIX_W-1:0] lim;
	logic [31:0]      lim32;
	logic             base_in, row_in, row_end;
	logic [PIX_W-1:0] pix_nx;
	logic [16:0]      col_nx;
	logic [31:0]      row_next;

	assign busy     = (state_q != S_IDLE);
	assign addr_req = start && !busy;

	assign x_lo = (x_pos < extent_x) ? x_pos : extent_x;
	assign x_hi = (x_pos < extent_x) ? extent_x : x_pos;
	assign y_lo = (y_pos < extent_y) ? y_pos : extent_y;
	assign y_hi = (y_pos < extent_y) ? extent_y : y_pos;

	// start point, pixels per row and row count of the incoming item
	always_comb begin
		addr_x = x_pos;
		addr_y = y_pos;
		cnt    = 16'd1;
		rws    = 16'd1;
		case (command)
			wfb_pkg::CMD_HSPAN: begin
				addr_x = x_lo;
				cnt    = x_hi - x_lo;
			end
			wfb_pkg::CMD_VSPAN: begin
				addr_y = y_lo;
				rws    = y_hi - y_lo;
			end
			wfb_pkg::CMD_RECT: begin
				cnt = extent_x;
				rws = extent_y;
			end
			default: begin
			end
		endcase
	end

	// write limit: smaller of the used count and the store depth
	assign lim = (32'(cfg.buffer_pixels_used) > 32'(BUFFER_PIXELS)) ?
		PIX_W'(BUFFER_PIXELS) : PIX_W'(cfg.buffer_pixels_used);
	assign lim32 = 32'(lim);

	assign base_in  = addr_base < lim32;
	assign row_in   = row_addr_q < lim32;
	assign pix_nx   = pix_q + PIX_W'(1);
	assign col_nx   = {1'b0, col_q} + 17'd1;
	assign row_end  = (col_nx == {1'b0, count_q}) || (pix_nx >= lim);
	assign row_next = row_addr_q + {16'd0, cfg.window_width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						count_q <= cnt;
						rows_q  <= rws;
						color_q <= color;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					if (addr_valid) begin
						row_addr_q   <= addr_base;
						read_color_q <= 16'd0;
						status_q     <= 1'b0;
						if (cmd_q == wfb_pkg::CMD_READ) begin
							if (base_in) begin
								state_q <= S_RDWAIT;
							end else begin
								status_q <= 1'b1;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end else if (cmd_q inside {wfb_pkg::CMD_DOT, wfb_pkg::CMD_HSPAN,
								wfb_pkg::CMD_VSPAN, wfb_pkg::CMD_RECT}) begin
							state_q <= S_ROW;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_ROW: begin
					if (rows_q == 16'd0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (row_in && count_q != 16'd0) begin
						pix_q   <= row_addr_q[PIX_W-1:0];
						col_q   <= 16'd0;
						state_q <= S_RUN;
					end else begin
						// row starts past the limit or is empty: skip it
						row_addr_q <= row_next;
						rows_q     <= rows_q - 16'd1;
					end
				end
				S_RUN: begin
					if (row_end) begin
						row_addr_q <= row_next;
						rows_q     <= rows_q - 16'd1;
						state_q    <= S_ROW;
					end else begin
						pix_q <= pix_nx;
						col_q <= col_nx[15:0];
					end
				end
				S_RDWAIT: begin
					read_color_q <= mem_rdata;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign mem_we    = (state_q == S_RUN);
	assign mem_waddr = pix_q[AW-1:0];
	assign mem_wdata = color_q;
	assign mem_re    = (state_q == S_ADDR) && addr_valid &&
		(cmd_q == wfb_pkg::CMD_READ) && base_in;
	assign mem_raddr = addr_base[AW-1:0];

	assign done       = done_q;
	assign read_color = read_color_q;
	assign status     = status_q;

endmodule

`default_nettype wire

// File: sv/window_framebuffer_draw_engine.sv
// Top level of the window frame-buffer draw engine: configuration registers and
// the wiring of wfb_ctrl, wfb_addr_unit and wfb_pixel_mem. Depends on wfb_pkg.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  config    cfg_we               cfg_index, cfg_data
//  command   start && !busy       command, x_pos, y_pos, extent_x, extent_y, color
//  result    done (one cycle)     read_color, status
//
// One item at a time. The address pipe forms the start address; each row of a
// span or rectangle then takes a step in S_ROW and a write for each pixel
// through the single write port; a read takes S_ADDR and then, in range, S_RDWAIT.
// done pulses the cycle after the last step; busy drops at the same edge.
// Reset zeroes the config and idles the engine; the pixel store is left undefined.
// The receiver cannot stall results.
`default_nettype none

module window_framebuffer_draw_engine #(
	parameter int BUFFER_PIXELS = wfb_pkg::BUFFER_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] x_pos,
	input  wire logic [15:0] y_pos,
	input  wire logic [15:0] extent_x,
	input  wire logic [15:0] extent_y,
	input  wire logic [15:0] color,
	output logic             done,
	output logic [15:0]      read_color,
	output logic             status
);

	localparam int AW = (BUFFER_PIXELS > 1) ? $clog2(BUFFER_PIXELS) : 1;

	wfb_pkg::cfg_t cfg_q;

	logic          addr_req;
	logic [15:0]   addr_x, addr_y;
	logic          addr_valid;
	logic [31:0]   addr_base;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wfb_pkg::CFG_ORIGIN_X:    cfg_q.origin_x           <= cfg_data[15:0];
				wfb_pkg::CFG_ORIGIN_Y:    cfg_q.origin_y           <= cfg_data[15:0];
				wfb_pkg::CFG_WINDOW_W:    cfg_q.window_width       <= cfg_data[15:0];
				wfb_pkg::CFG_PIXELS_USED: cfg_q.buffer_pixels_used <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wfb_ctrl #(
		.BUFFER_PIXELS(BUFFER_PIXELS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.command    (command),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.extent_x   (extent_x),
		.extent_y   (extent_y),
		.color      (color),
		.busy       (busy),
		.addr_req   (addr_req),
		.addr_x     (addr_x),
		.addr_y     (addr_y),
		.addr_valid (addr_valid),
		.addr_base  (addr_base),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.done       (done),
		.read_color (read_color),
		.status     (status)
	);

	wfb_addr_unit u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (addr_req),
		.x      (addr_x),
		.y      (addr_y),
		.valid  (addr_valid),
		.addr   (addr_base)
	);

	wfb_pixel_mem #(
		.DEPTH(BUFFER_PIXELS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
